### src/cct_pkg.sv
// shared types, widths and helpers of the charge current cap tracker
// no dependencies; imported by every module of the block
package cct_pkg;

    // field widths
    localparam int CAP_W      = 25;
    localparam int TIME_W     = 48;
    localparam int LIM_W      = 20;
    localparam int MARGIN_W   = 16;
    localparam int VOLT_W     = 10;
    localparam int AGE_W      = 32;
    localparam int RVAL_W     = 24;
    localparam int PHASE_W    = 2;
    localparam int LOWER_W    = LIM_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // power to current divider: |W * 1000| over volts, times phases unless the reading is per phase
    localparam int MILLI      = 1000;
    localparam int PROD_W     = 34;
    localparam int DIVD_W     = PROD_W - 1;
    localparam int DVSR_W     = 12;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

    // candidate before saturation
    localparam int WIDE_W     = 35;
    localparam logic signed [WIDE_W-1:0] WIDE_CAP_MAX = WIDE_W'(2 ** (CAP_W - 1) - 1);
    localparam logic signed [WIDE_W-1:0] WIDE_CAP_MIN = ~WIDE_CAP_MAX;

    // command queue between front and back
    localparam int CMD_Q_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARGIN      = 3'd0,
        CFG_START_LOWER = 3'd1,
        CFG_VOLTAGE     = 3'd2,
        CFG_MAX_AGE     = 3'd3,
        CFG_HOLD        = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_NONE        = 2'd0,
        KIND_CURRENT     = 2'd1,
        KIND_PHASE_POWER = 2'd2,
        KIND_TOTAL_POWER = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SRC_START    = 2'd0,
        SRC_MEASURED = 2'd1,
        SRC_NO_MEAS  = 2'd2,
        SRC_HOLD     = 2'd3
    } t_src;

    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_RUN   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MEAS_NONE    = 2'd0,
        MEAS_CURRENT = 2'd1,
        MEAS_POWER   = 2'd2
    } t_meas;

    // configuration register set
    typedef struct packed {
        logic [MARGIN_W-1:0] margin;
        logic                start_lower;
        logic [VOLT_W-1:0]   volts;
        logic [AGE_W-1:0]    max_age;
        logic [AGE_W-1:0]    hold;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        t_op                       op;
        t_meas                     meas;
        logic [LOWER_W-1:0]        lower;
        logic [LIM_W-1:0]          max_ma;
        logic [TIME_W-1:0]         now;
        logic signed [RVAL_W-1:0]  rval;
        logic [DIVD_W-1:0]         mag;
        logic                      neg;
        logic [DVSR_W-1:0]         dvsr;
    } t_cmd;

    // saturate a wide candidate to the cap range
    function automatic logic signed [CAP_W-1:0] sat_cap(input logic signed [WIDE_W-1:0] v);
        logic signed [CAP_W-1:0] r;
        if (v > WIDE_CAP_MAX) begin
            r = WIDE_CAP_MAX[CAP_W-1:0];
        end else if (v < WIDE_CAP_MIN) begin
            r = WIDE_CAP_MIN[CAP_W-1:0];
        end else begin
            r = v[CAP_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/cct_in_if.sv
// input channel of the cap tracker: one optimizer run per transfer
// valid/ready handshake, no dependencies
interface cct_in_if;
    logic               valid;
    logic               ready;
    logic               session_on;
    logic               drawing;
    logic               max_limit_valid;
    logic [19:0]        max_limit_ma;
    logic [19:0]        min_limit_ma;
    logic [1:0]         phase_count;
    logic [47:0]        now_ms;
    logic [47:0]        reading_time_ms;
    logic [1:0]         reading_kind;
    logic signed [23:0] reading_value;

    modport source (
        output valid, session_on, drawing, max_limit_valid, max_limit_ma,
               min_limit_ma, phase_count, now_ms, reading_time_ms,
               reading_kind, reading_value,
        input  ready
    );

    modport sink (
        input  valid, session_on, drawing, max_limit_valid, max_limit_ma,
               min_limit_ma, phase_count, now_ms, reading_time_ms,
               reading_kind, reading_value,
        output ready
    );
endinterface

### src/cct_out_if.sv
// output channel of the cap tracker: one cap result per transfer
// valid/ready handshake, no dependencies
interface cct_out_if;
    logic               valid;
    logic               ready;
    logic               cap_valid;
    logic signed [24:0] cap_ma;
    logic [1:0]         cap_source;

    modport source (
        output valid, cap_valid, cap_ma, cap_source,
        input  ready
    );

    modport sink (
        input  valid, cap_valid, cap_ma, cap_source,
        output ready
    );
endinterface

### src/charge_current_cap_tracker_unit.sv
// top level of the charge current cap tracker: config registers and wiring
// depends on cct_pkg, cct_in_if, cct_out_if, cct_front, cct_cmd_fifo, cct_back
//
// channel   dir  handshake      contents
// i_in      in   valid/ready    session flags, limits, times, one meter reading
// o_out     out  valid/ready    cap_valid, cap_ma, cap_source
// i_cfg_*   in   write enable   margin, start mode, voltage, max age, hold time
//
// a running session with a fresh power reading is taken from the queue,
// divided bit-serially, then the cap is updated; every other run is taken
// and updated. the front accepts into a two-entry queue; the back may take
// and divide the next run while a result waits, but its update stalls until
// that result is taken. reset is synchronous and needs no clearing pass.
module charge_current_cap_tracker_unit
    import cct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cct_in_if.sink                i_in,
    cct_out_if.source             o_out
);

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.margin      <= '0;
            r_cfg.start_lower <= 1'b0;
            r_cfg.volts       <= VOLT_W'(230);
            r_cfg.max_age     <= AGE_W'(10000);
            r_cfg.hold        <= AGE_W'(30000);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MARGIN:      r_cfg.margin      <= i_cfg_data[MARGIN_W-1:0];
                CFG_START_LOWER: r_cfg.start_lower <= i_cfg_data[0];
                CFG_VOLTAGE:     r_cfg.volts       <= i_cfg_data[VOLT_W-1:0];
                CFG_MAX_AGE:     r_cfg.max_age     <= i_cfg_data[AGE_W-1:0];
                CFG_HOLD:        r_cfg.hold        <= i_cfg_data[AGE_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // front end
    cct_front u_front (
        .i_cfg  (r_cfg),
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    // command queue
    cct_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    // back end
    cct_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### src/cct_front.sv
// front end: accepts a run, checks reading freshness and prepares the division
// depends on cct_pkg and cct_in_if
module cct_front
    import cct_pkg::*;
(
    input  t_cfg     i_cfg,
    cct_in_if.sink   i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [TIME_W:0]         age;
    logic                    fresh;
    logic [PHASE_W-1:0]      phases;
    t_kind                   kind;
    logic signed [PROD_W-1:0] prod;

    // accept whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    assign kind   = t_kind'(i_in.reading_kind);
    assign phases = (i_in.phase_count == '0) ? PHASE_W'(1) : i_in.phase_count;

    // reading age, negative counts as fresh
    assign age   = {1'b0, i_in.now_ms} - {1'b0, i_in.reading_time_ms};
    assign fresh = age[TIME_W] || (age[TIME_W-1:0] <= TIME_W'(i_cfg.max_age));

    // scaled power, split into sign and magnitude for the divider
    assign prod = PROD_W'(i_in.reading_value) * PROD_W'(MILLI);

    // classify the run
    always_comb begin
        o_cmd        = '0;
        o_cmd.lower  = LOWER_W'(i_in.min_limit_ma) + LOWER_W'(i_cfg.margin);
        o_cmd.max_ma = i_in.max_limit_ma;
        o_cmd.now    = i_in.now_ms;
        o_cmd.rval   = i_in.reading_value;
        o_cmd.neg    = prod[PROD_W-1];
        o_cmd.mag    = prod[PROD_W-1] ? DIVD_W'(-prod) : prod[DIVD_W-1:0];
        o_cmd.dvsr   = (kind == KIND_PHASE_POWER) ? DVSR_W'(i_cfg.volts)
                                                  : DVSR_W'(i_cfg.volts) * DVSR_W'(phases);

        if (!i_in.session_on) begin
            o_cmd.op = OP_PASS;
        end else if (!i_in.drawing || !i_in.max_limit_valid) begin
            o_cmd.op = OP_CLEAR;
        end else begin
            o_cmd.op = OP_RUN;
        end

        o_cmd.meas = MEAS_NONE;
        if (fresh) begin
            case (kind)
                KIND_CURRENT: begin
                    o_cmd.meas = MEAS_CURRENT;
                end
                KIND_PHASE_POWER, KIND_TOTAL_POWER: begin
                    if (i_cfg.volts != '0) begin
                        o_cmd.meas = MEAS_POWER;
                    end
                end
                default: begin
                    o_cmd.meas = MEAS_NONE;
                end
            endcase
        end
    end

endmodule

### src/cct_cmd_fifo.sv
// short command queue between front and back
// depends on cct_pkg
module cct_cmd_fifo
    import cct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);

    t_cmd             r_mem [CMD_Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(CMD_Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/cct_back.sv
// back end: serial divider, cap and pending-reduction state, output register
// depends on cct_pkg and cct_out_if
module cct_back
    import cct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    cct_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EVAL = 3'b100
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic                     r_hold_wait;
    logic                     r_cap_present;
    logic signed [CAP_W-1:0]  r_cap_value;
    logic                     r_pend_present;
    logic [TIME_W-1:0]        r_pend_since;
    logic [DVSR_W-1:0]        r_rem;
    logic [DIVD_W-1:0]        r_quo;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic                     r_out_valid;
    logic                     r_out_cap_valid;
    logic signed [CAP_W-1:0]  r_out_cap_ma;
    t_src                     r_out_src;

    logic [TIME_W:0]          elapsed;
    logic                     n_hold_wait;
    logic [DVSR_W:0]          shifted;
    logic [DVSR_W:0]          trial;
    logic                     ld;
    logic signed [PROD_W-1:0] quot_s;
    logic signed [WIDE_W-1:0] wide;
    logic signed [CAP_W-1:0]  cand;
    t_src                     cand_src;
    logic signed [CAP_W-1:0]  cur_cap;
    t_src                     cur_src;
    logic                     hold;

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign ld    = !r_out_valid || o_out.ready;

    // hold check against the state left by the previous run
    assign elapsed     = {1'b0, i_head.now} - {1'b0, r_pend_since};
    assign n_hold_wait = r_pend_present
                         ? (elapsed[TIME_W] || (elapsed[TIME_W-1:0] < TIME_W'(i_cfg.hold)))
                         : (i_cfg.hold != '0);

    // one restoring divide step
    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign trial   = shifted - {1'b0, r_cmd.dvsr};

    // candidate and cap currently in effect
    assign quot_s = r_cmd.neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    always_comb begin
        case (r_cmd.meas)
            MEAS_CURRENT: begin
                wide     = WIDE_W'($signed(r_cmd.rval)) + WIDE_W'(i_cfg.margin);
                cand_src = SRC_MEASURED;
            end
            MEAS_POWER: begin
                wide     = WIDE_W'(quot_s) + WIDE_W'(i_cfg.margin);
                cand_src = SRC_MEASURED;
            end
            default: begin
                wide     = WIDE_W'(r_cmd.lower);
                cand_src = SRC_NO_MEAS;
            end
        endcase
        cand = sat_cap(wide);

        if (r_cap_present) begin
            cur_cap = r_cap_value;
            cur_src = SRC_HOLD;
        end else begin
            cur_cap = i_cfg.start_lower ? CAP_W'(r_cmd.lower) : CAP_W'(r_cmd.max_ma);
            cur_src = SRC_START;
        end

        hold = (cand < cur_cap) && r_hold_wait;
    end

    // sequencer, divider and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cap_present  <= 1'b0;
            r_pend_present <= 1'b0;
            r_pend_since   <= '0;
            r_out_valid    <= 1'b0;
            r_cnt          <= '0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_EVAL) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd       <= i_head;
                        r_hold_wait <= n_hold_wait;
                        r_rem       <= '0;
                        r_quo       <= i_head.mag;
                        if (i_head.op == OP_RUN && i_head.meas == MEAS_POWER) begin
                            r_cnt   <= DIV_CNT_W'(DIVD_W);
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_DIV: begin
                    if (!trial[DVSR_W]) begin
                        r_rem <= trial[DVSR_W-1:0];
                        r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
                    end else begin
                        r_rem <= shifted[DVSR_W-1:0];
                        r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(1)) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (ld) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        case (r_cmd.op)
                            OP_RUN: begin
                                r_cap_present <= 1'b1;
                                r_out_cap_valid <= 1'b1;
                                if (hold) begin
                                    r_cap_value    <= cur_cap;
                                    r_pend_present <= 1'b1;
                                    if (!r_pend_present) begin
                                        r_pend_since <= r_cmd.now;
                                    end
                                    r_out_cap_ma <= cur_cap;
                                    r_out_src    <= cur_src;
                                end else begin
                                    r_cap_value    <= cand;
                                    r_pend_present <= 1'b0;
                                    r_pend_since   <= '0;
                                    r_out_cap_ma   <= cand;
                                    r_out_src      <= cand_src;
                                end
                            end
                            OP_CLEAR: begin
                                r_cap_present   <= 1'b0;
                                r_cap_value     <= '0;
                                r_pend_present  <= 1'b0;
                                r_pend_since    <= '0;
                                r_out_cap_valid <= 1'b0;
                                r_out_cap_ma    <= '0;
                                r_out_src       <= SRC_START;
                            end
                            default: begin
                                r_out_cap_valid <= 1'b0;
                                r_out_cap_ma    <= '0;
                                r_out_src       <= SRC_START;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register drives the channel
    assign o_out.valid      = r_out_valid;
    assign o_out.cap_valid  = r_out_cap_valid;
    assign o_out.cap_ma     = r_out_cap_ma;
    assign o_out.cap_source = r_out_src;

    // a pending reduction only exists under a cap
    a_pend_needs_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_present |-> r_cap_present)
        else $error("pending reduction without a cap");

    // the divider only runs for a fresh power reading
    a_div_only_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cmd.op == OP_RUN && r_cmd.meas == MEAS_POWER))
        else $error("divider running for a non-power run");

    // a run always leaves a cap and a valid result behind
    a_run_sets_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && ld && r_cmd.op == OP_RUN)
        |=> (r_cap_present && r_out_valid && r_out_cap_valid))
        else $error("run did not set a cap");

    // clearing drops both the cap and any pending reduction
    a_clear_drops_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && ld && r_cmd.op == OP_CLEAR)
        |=> (!r_cap_present && !r_pend_present && !r_out_cap_valid))
        else $error("clear left tracker state behind");

endmodule
